// ----- src/sqvt_pkg.sv -----
// shared types, constants and trig coefficient tables for the sprite quad vertex transform
// no dependencies; imported by every module of the block

package sqvt_pkg;

    // fixed point format of positions and angle resolution
    localparam int FRAC_BITS  = 8;
    localparam int ANGLE_BITS = 16;
    localparam int QBITS      = ANGLE_BITS - 2;

    // field widths
    localparam int POS_W   = 24;
    localparam int SCALE_W = 16;
    localparam int ANGLE_W = 16;
    localparam int UV_W    = 15;
    localparam int TEX_W   = 16;
    localparam int COLOR_W = 32;

    // trig datapath widths
    localparam int T_W    = 31;
    localparam int T2_W   = 32;
    localparam int R_W    = 31;
    localparam int RND_W  = 17;
    localparam int TRIG_W = 18;

    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    // horner divisors and their reciprocals, floor(2^32 / k)
    localparam int SIN_STEPS = 5;
    localparam int COS_STEPS = 6;
    localparam logic [7:0] SIN_K [SIN_STEPS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [7:0] COS_K [COS_STEPS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
    localparam logic [31:0] SIN_RECIP [SIN_STEPS] = '{
        32'((64'd1 << 32) / 64'd110), 32'((64'd1 << 32) / 64'd72),
        32'((64'd1 << 32) / 64'd42),  32'((64'd1 << 32) / 64'd20),
        32'((64'd1 << 32) / 64'd6)
    };
    localparam logic [31:0] COS_RECIP [COS_STEPS] = '{
        32'((64'd1 << 32) / 64'd132), 32'((64'd1 << 32) / 64'd90),
        32'((64'd1 << 32) / 64'd56),  32'((64'd1 << 32) / 64'd30),
        32'((64'd1 << 32) / 64'd12),  32'((64'd1 << 32) / 64'd2)
    };

    // item delay from the phase stage to the quadrant stage
    localparam int ITEM_DELAY = 2 + 3 * COS_STEPS;

    // geometry datapath widths
    localparam int LX_W    = UV_W + FRAC_BITS;
    localparam int DIFF_W  = ((LX_W > POS_W - 1) ? LX_W : POS_W - 1) + 2;
    localparam int PROD_W  = DIFF_W + SCALE_W;
    localparam int SX_W    = PROD_W - 8;
    localparam int RP_W    = SX_W + TRIG_W;
    localparam int RX_W    = RP_W + 1 - 16;

    // corner codes and emission order
    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_TR = 2'd1;
    localparam logic [1:0] CORNER_BL = 2'd2;
    localparam logic [1:0] CORNER_BR = 2'd3;
    localparam int BEAT_W = 3;
    localparam logic [BEAT_W-1:0] LAST_BEAT = 3'd5;
    localparam logic [1:0] ORDER [6] = '{CORNER_TL, CORNER_TR, CORNER_BL,
                                         CORNER_TR, CORNER_BR, CORNER_BL};

    typedef struct packed {
        logic signed [POS_W-1:0]   pos_x;
        logic signed [POS_W-1:0]   pos_y;
        logic signed [POS_W-1:0]   pivot_x;
        logic signed [POS_W-1:0]   pivot_y;
        logic signed [SCALE_W-1:0] scale_x;
        logic signed [SCALE_W-1:0] scale_y;
        logic [ANGLE_W-1:0]        angle;
        logic [UV_W-1:0]           uv_x;
        logic [UV_W-1:0]           uv_y;
        logic [UV_W-1:0]           uv_width;
        logic [UV_W-1:0]           uv_height;
        logic [COLOR_W-1:0]        color;
    } item_t;

    typedef struct packed {
        logic            valid;
        logic [T_W-1:0]  t;
        logic [T2_W-1:0] t2;
    } trig_lane_t;

    typedef struct packed {
        logic [3:0][POS_W-1:0] vx;
        logic [3:0][POS_W-1:0] vy;
        logic [TEX_W-1:0]      u0;
        logic [TEX_W-1:0]      u1;
        logic [TEX_W-1:0]      v0;
        logic [TEX_W-1:0]      v1;
        logic [COLOR_W-1:0]    color;
    } quad_t;

endpackage

// ----- src/sqvt_horner_step.sv -----
// one horner step of the sine/cosine series: n = 1 - (t2 * r) / k, clamped at zero
// three register stages; depends on sqvt_pkg

module sqvt_horner_step (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [7:0]                  k,
    input  logic [31:0]                 recip,
    input  sqvt_pkg::trig_lane_t        lane_in,
    input  logic [sqvt_pkg::R_W-1:0]    r_in,
    output sqvt_pkg::trig_lane_t        lane_out,
    output logic [sqvt_pkg::R_W-1:0]    r_out
);
    import sqvt_pkg::*;

    trig_lane_t  lane1_reg, lane2_reg, lane3_reg;
    logic [31:0] p1_reg, p2_reg, qe_reg;
    logic [R_W-1:0] r_reg, r_next;
    logic [62:0] prod1;
    logic [63:0] prod2;
    logic [39:0] qk, rem;
    logic [32:0] q, n;

    assign prod1 = 63'(lane_in.t2) * 63'(r_in);
    assign prod2 = 64'(p1_reg) * 64'(recip);

    // reciprocal estimate is at most one low, fix with one compare
    always_comb
    begin
        qk  = 40'(qe_reg) * 40'(k);
        rem = 40'(p2_reg) - qk;
        q   = 33'(qe_reg) + 33'(rem >= 40'(k));
        n   = 33'(ONE_Q30) - q;
        if (n[32])
        begin
            r_next = '0;
        end
        else
        begin
            r_next = n[R_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane1_reg <= '0;
            lane2_reg <= '0;
            lane3_reg <= '0;
        end
        else
        begin
            lane1_reg <= lane_in;
            lane2_reg <= lane1_reg;
            lane3_reg <= lane2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg <= prod1[61:30];
        p2_reg <= p1_reg;
        qe_reg <= prod2[63:32];
        r_reg  <= r_next;
    end

    assign lane_out = lane3_reg;
    assign r_out    = r_reg;

endmodule

// ----- src/sqvt_trig.sv -----
// sine and cosine of the sprite angle: phase reduction, two horner chains, quadrant fix-up
// depends on sqvt_pkg and sqvt_horner_step

module sqvt_trig (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  sqvt_pkg::item_t                     in_item,
    output logic                                out_valid,
    output sqvt_pkg::item_t                     out_item,
    output logic signed [sqvt_pkg::TRIG_W-1:0]  sn,
    output logic signed [sqvt_pkg::TRIG_W-1:0]  cs
);
    import sqvt_pkg::*;

    typedef struct packed {
        item_t      item;
        logic [1:0] quad;
    } line_t;

    logic [ANGLE_BITS+15:0] wide_angle;
    logic [ANGLE_BITS-1:0]  phase;
    logic [QBITS+30:0]      tprod;
    logic [61:0]            tsq, sprod;

    logic            a_valid_reg;
    logic [T_W-1:0]  a_t_reg;
    logic            b_valid_reg;
    logic [T_W-1:0]  b_t_reg;
    logic [T2_W-1:0] b_t2_reg;
    trig_lane_t      b_lane;
    line_t           line_reg [ITEM_DELAY];

    trig_lane_t      sin_lane [SIN_STEPS+1];
    logic [R_W-1:0]  sin_r    [SIN_STEPS+1];
    trig_lane_t      cos_lane [COS_STEPS+1];
    logic [R_W-1:0]  cos_r    [COS_STEPS+1];

    logic             c1_valid_reg, c2_valid_reg, c3_valid_reg;
    logic [61:0]      c1_prod_reg;
    logic [RND_W-1:0] c2_s_reg, c3_s_reg, s_next;
    logic [31:0]      s_raw, s_cl, s_add, c_add;
    logic [RND_W-1:0] c_rnd;

    logic                     out_valid_reg;
    item_t                    out_item_reg;
    logic signed [TRIG_W-1:0] sn_reg, cs_reg, sn_next, cs_next, s_pos, c_pos;

    // phase: angle rescaled to ANGLE_BITS, top two bits pick the quadrant
    assign wide_angle = {in_item.angle, ANGLE_BITS'(0)};
    assign phase      = wide_angle[ANGLE_BITS+15:16];
    assign tprod      = (QBITS+31)'(phase[QBITS-1:0]) * (QBITS+31)'(HALF_PI_Q30);
    assign tsq        = 62'(a_t_reg) * 62'(a_t_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_t_reg     <= tprod[QBITS+30:QBITS];
        b_t_reg     <= a_t_reg;
        b_t2_reg    <= tsq[61:30];
        line_reg[0] <= '{item: in_item, quad: phase[ANGLE_BITS-1:ANGLE_BITS-2]};
        for (int i = 1; i < ITEM_DELAY; i++)
        begin
            line_reg[i] <= line_reg[i-1];
        end
    end

    assign b_lane      = '{valid: b_valid_reg, t: b_t_reg, t2: b_t2_reg};
    assign sin_lane[0] = b_lane;
    assign sin_r[0]    = ONE_Q30;
    assign cos_lane[0] = b_lane;
    assign cos_r[0]    = ONE_Q30;

    for (genvar i = 0; i < SIN_STEPS; i++)
    begin : g_sin
        sqvt_horner_step u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .k        (SIN_K[i]),
            .recip    (SIN_RECIP[i]),
            .lane_in  (sin_lane[i]),
            .r_in     (sin_r[i]),
            .lane_out (sin_lane[i+1]),
            .r_out    (sin_r[i+1])
        );
    end

    for (genvar i = 0; i < COS_STEPS; i++)
    begin : g_cos
        sqvt_horner_step u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .k        (COS_K[i]),
            .recip    (COS_RECIP[i]),
            .lane_in  (cos_lane[i]),
            .r_in     (cos_r[i]),
            .lane_out (cos_lane[i+1]),
            .r_out    (cos_r[i+1])
        );
    end

    // sine tail: multiply by t, clamp to one, round to q16; one spare stage to meet cosine
    assign sprod = 62'(sin_lane[SIN_STEPS].t) * 62'(sin_r[SIN_STEPS]);

    always_comb
    begin
        s_raw = c1_prod_reg[61:30];
        s_cl  = (s_raw > 32'(ONE_Q30)) ? 32'(ONE_Q30) : s_raw;
        s_add = s_cl + 32'd8192;
        s_next = s_add[30:14];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg  <= 1'b0;
            c2_valid_reg  <= 1'b0;
            c3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            c1_valid_reg  <= sin_lane[SIN_STEPS].valid;
            c2_valid_reg  <= c1_valid_reg;
            c3_valid_reg  <= c2_valid_reg;
            out_valid_reg <= c3_valid_reg & cos_lane[COS_STEPS].valid;
        end
    end

    // quadrant swap and negate
    always_comb
    begin
        c_add = 32'(cos_r[COS_STEPS]) + 32'd8192;
        c_rnd = c_add[30:14];
        s_pos = TRIG_W'(c3_s_reg);
        c_pos = TRIG_W'(c_rnd);
        case (line_reg[ITEM_DELAY-1].quad)
            2'd0:
            begin
                sn_next = s_pos;
                cs_next = c_pos;
            end
            2'd1:
            begin
                sn_next = c_pos;
                cs_next = -s_pos;
            end
            2'd2:
            begin
                sn_next = -s_pos;
                cs_next = -c_pos;
            end
            default:
            begin
                sn_next = -c_pos;
                cs_next = s_pos;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        c1_prod_reg  <= sprod;
        c2_s_reg     <= s_next;
        c3_s_reg     <= c2_s_reg;
        sn_reg       <= sn_next;
        cs_reg       <= cs_next;
        out_item_reg <= line_reg[ITEM_DELAY-1].item;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign sn        = sn_reg;
    assign cs        = cs_reg;

endmodule

// ----- src/sqvt_geom.sv -----
// corner geometry: pivot and scale, rotation, position add with saturation, texture corners
// four register stages; depends on sqvt_pkg

module sqvt_geom (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  sqvt_pkg::item_t                     in_item,
    input  logic signed [sqvt_pkg::TRIG_W-1:0]  sn,
    input  logic signed [sqvt_pkg::TRIG_W-1:0]  cs,
    output logic                                out_valid,
    output sqvt_pkg::quad_t                     out_quad
);
    import sqvt_pkg::*;

    localparam logic signed [RX_W:0] SAT_HI = (RX_W+1)'(8388607);
    localparam logic signed [RX_W:0] SAT_LO = -SAT_HI - (RX_W+1)'(1);

    function automatic logic signed [SX_W-1:0] scale_round(
        input logic signed [DIFF_W-1:0]  d,
        input logic signed [SCALE_W-1:0] s
    );
        logic signed [PROD_W-1:0] p;
        p = PROD_W'(d) * PROD_W'(s);
        p = p + PROD_W'(128);
        return p[PROD_W-1:8];
    endfunction

    function automatic logic [POS_W-1:0] saturate(input logic signed [RX_W:0] v);
        logic signed [RX_W:0] c;
        c = v;
        if (v > SAT_HI)
        begin
            c = SAT_HI;
        end
        if (v < SAT_LO)
        begin
            c = SAT_LO;
        end
        return c[POS_W-1:0];
    endfunction

    logic [3:0] valid_reg;
    item_t      g1_item_reg, g2_item_reg, g3_item_reg;
    logic signed [TRIG_W-1:0] g1_sn_reg, g1_cs_reg;
    logic signed [SX_W-1:0]   sx_reg [2], sy_reg [2];
    logic signed [RP_W-1:0]   sxc_reg [2], sxs_reg [2], syc_reg [2], sys_reg [2];
    logic signed [RX_W-1:0]   rx_reg [4], ry_reg [4];
    logic signed [RX_W-1:0]   rx_next [4], ry_next [4];
    logic signed [DIFF_W-1:0] dx0, dx1, dy0, dy1;
    logic signed [RP_W:0]     ax, ay;
    quad_t quad_reg, quad_next;

    // pivot-relative corner offsets along each axis
    always_comb
    begin
        dx0 = -DIFF_W'(in_item.pivot_x);
        dy0 = -DIFF_W'(in_item.pivot_y);
        dx1 = DIFF_W'(signed'({1'b0, in_item.uv_width, FRAC_BITS'(0)})) - DIFF_W'(in_item.pivot_x);
        dy1 = DIFF_W'(signed'({1'b0, in_item.uv_height, FRAC_BITS'(0)})) - DIFF_W'(in_item.pivot_y);
    end

    // rotation sums, rounded half up by 16 bits
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            ax = (RP_W+1)'(sxc_reg[k%2]) - (RP_W+1)'(sys_reg[k/2]) + (RP_W+1)'(32768);
            ay = (RP_W+1)'(sxs_reg[k%2]) + (RP_W+1)'(syc_reg[k/2]) + (RP_W+1)'(32768);
            rx_next[k] = ax[RP_W:16];
            ry_next[k] = ay[RP_W:16];
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            quad_next.vx[k] = saturate((RX_W+1)'(g3_item_reg.pos_x) + (RX_W+1)'(rx_reg[k]));
            quad_next.vy[k] = saturate((RX_W+1)'(g3_item_reg.pos_y) + (RX_W+1)'(ry_reg[k]));
        end
        quad_next.u0    = TEX_W'(g3_item_reg.uv_x);
        quad_next.u1    = TEX_W'(g3_item_reg.uv_x) + TEX_W'(g3_item_reg.uv_width);
        quad_next.v0    = TEX_W'(g3_item_reg.uv_y);
        quad_next.v1    = TEX_W'(g3_item_reg.uv_y) + TEX_W'(g3_item_reg.uv_height);
        quad_next.color = g3_item_reg.color;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        g1_item_reg <= in_item;
        g1_sn_reg   <= sn;
        g1_cs_reg   <= cs;
        sx_reg[0]   <= scale_round(dx0, in_item.scale_x);
        sx_reg[1]   <= scale_round(dx1, in_item.scale_x);
        sy_reg[0]   <= scale_round(dy0, in_item.scale_y);
        sy_reg[1]   <= scale_round(dy1, in_item.scale_y);
        g2_item_reg <= g1_item_reg;
        for (int i = 0; i < 2; i++)
        begin
            sxc_reg[i] <= RP_W'(sx_reg[i]) * RP_W'(g1_cs_reg);
            sxs_reg[i] <= RP_W'(sx_reg[i]) * RP_W'(g1_sn_reg);
            syc_reg[i] <= RP_W'(sy_reg[i]) * RP_W'(g1_cs_reg);
            sys_reg[i] <= RP_W'(sy_reg[i]) * RP_W'(g1_sn_reg);
        end
        g3_item_reg <= g2_item_reg;
        for (int k = 0; k < 4; k++)
        begin
            rx_reg[k] <= rx_next[k];
            ry_reg[k] <= ry_next[k];
        end
        quad_reg <= quad_next;
    end

    assign out_valid = valid_reg[3];
    assign out_quad  = quad_reg;

endmodule

// ----- src/sqvt_emit.sv -----
// vertex sequencer: holds one finished quad and sends its six vertices, one beat a cycle
// depends on sqvt_pkg

module sqvt_emit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  sqvt_pkg::quad_t                      in_quad,
    output logic                                 done,
    output logic signed [sqvt_pkg::POS_W-1:0]    vertex_x,
    output logic signed [sqvt_pkg::POS_W-1:0]    vertex_y,
    output logic [sqvt_pkg::TEX_W-1:0]           tex_u,
    output logic [sqvt_pkg::TEX_W-1:0]           tex_v,
    output logic [sqvt_pkg::COLOR_W-1:0]         vertex_color,
    output logic [1:0]                           corner,
    output logic                                 last
);
    import sqvt_pkg::*;

    quad_t             hold_reg;
    logic              act_reg, act_next;
    logic [BEAT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]        sel;

    logic              done_reg, last_reg;
    logic [POS_W-1:0]  vx_reg, vy_reg;
    logic [TEX_W-1:0]  u_reg, v_reg;
    logic [COLOR_W-1:0] color_reg;
    logic [1:0]        corner_reg;

    always_comb
    begin
        act_next = act_reg;
        cnt_next = cnt_reg;
        if (in_valid)
        begin
            act_next = 1'b1;
            cnt_next = '0;
        end
        else if (act_reg)
        begin
            if (cnt_reg == LAST_BEAT)
            begin
                act_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + BEAT_W'(1);
            end
        end
    end

    assign sel = ORDER[cnt_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            act_reg  <= act_next;
            cnt_reg  <= cnt_next;
            done_reg <= act_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            hold_reg <= in_quad;
        end
        vx_reg     <= hold_reg.vx[sel];
        vy_reg     <= hold_reg.vy[sel];
        u_reg      <= sel[0] ? hold_reg.u1 : hold_reg.u0;
        v_reg      <= sel[1] ? hold_reg.v1 : hold_reg.v0;
        color_reg  <= hold_reg.color;
        corner_reg <= sel;
        last_reg   <= act_reg && (cnt_reg == LAST_BEAT);
    end

    assign done         = done_reg;
    assign vertex_x     = vx_reg;
    assign vertex_y     = vy_reg;
    assign tex_u        = u_reg;
    assign tex_v        = v_reg;
    assign vertex_color = color_reg;
    assign corner       = corner_reg;
    assign last         = last_reg & done_reg;

`ifndef SYNTHESIS
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> (!act_reg || cnt_reg == LAST_BEAT))
        else $error("quad arrived while previous quad still sending");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        act_reg |-> (cnt_reg <= LAST_BEAT))
        else $error("beat counter out of range");
    a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (act_reg && cnt_reg == LAST_BEAT) |=> (done_reg && last_reg))
        else $error("sixth beat not marked last");
`endif

endmodule

// ----- src/sprite_quad_vertex_transform.sv -----
// top level of the sprite quad vertex transform
// depends on sqvt_pkg, sqvt_trig, sqvt_geom and sqvt_emit

// A sprite beat is taken at a rising edge with start high and busy low; busy then stays
// high while a counter loaded with LAST_BEAT runs down, so sprites enter no faster than the
// single vertex output sends them (six vertices per sprite). Each vertex is shown for exactly
// one cycle with done high and cannot be held off, so the receiver must take every beat. The
// six vertices of a sprite follow on consecutive cycles in corner order 0,1,2,1,3,2, the
// sixth with last set. The datapath is a deep pipeline: angle phase, two chains of
// three-stage horner steps for sine and cosine, then four geometry stages (scale, products,
// rotate, position with saturation). No state survives between sprites and reset only
// clears the valid bits, the counters and the lane registers of the horner steps.

module sprite_quad_vertex_transform (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [sqvt_pkg::POS_W-1:0]   pos_x,
    input  logic signed [sqvt_pkg::POS_W-1:0]   pos_y,
    input  logic signed [sqvt_pkg::POS_W-1:0]   pivot_x,
    input  logic signed [sqvt_pkg::POS_W-1:0]   pivot_y,
    input  logic signed [sqvt_pkg::SCALE_W-1:0] scale_x,
    input  logic signed [sqvt_pkg::SCALE_W-1:0] scale_y,
    input  logic [sqvt_pkg::ANGLE_W-1:0]        angle,
    input  logic [sqvt_pkg::UV_W-1:0]           uv_x,
    input  logic [sqvt_pkg::UV_W-1:0]           uv_y,
    input  logic [sqvt_pkg::UV_W-1:0]           uv_width,
    input  logic [sqvt_pkg::UV_W-1:0]           uv_height,
    input  logic [sqvt_pkg::COLOR_W-1:0]        color,
    output logic                                done,
    output logic signed [sqvt_pkg::POS_W-1:0]   vertex_x,
    output logic signed [sqvt_pkg::POS_W-1:0]   vertex_y,
    output logic [sqvt_pkg::TEX_W-1:0]          tex_u,
    output logic [sqvt_pkg::TEX_W-1:0]          tex_v,
    output logic [sqvt_pkg::COLOR_W-1:0]        vertex_color,
    output logic [1:0]                          corner,
    output logic                                last
);
    import sqvt_pkg::*;

    logic [BEAT_W-1:0] busy_cnt_reg, busy_cnt_next;
    logic              accept;
    item_t             item;

    logic                     trig_valid;
    item_t                    trig_item;
    logic signed [TRIG_W-1:0] trig_sn, trig_cs;
    logic                     geom_valid;
    quad_t                    geom_quad;

    // a beat is taken when start meets an idle input
    assign accept = start & ~busy;
    assign busy   = (busy_cnt_reg != '0);

    // input window: closed after each accepted beat until the busy counter runs down from LAST_BEAT
    always_comb
    begin
        busy_cnt_next = busy_cnt_reg;
        if (accept)
        begin
            busy_cnt_next = LAST_BEAT;
        end
        else if (busy)
        begin
            busy_cnt_next = busy_cnt_reg - BEAT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_cnt_reg <= '0;
        end
        else
        begin
            busy_cnt_reg <= busy_cnt_next;
        end
    end

    always_comb
    begin
        item.pos_x     = pos_x;
        item.pos_y     = pos_y;
        item.pivot_x   = pivot_x;
        item.pivot_y   = pivot_y;
        item.scale_x   = scale_x;
        item.scale_y   = scale_y;
        item.angle     = angle;
        item.uv_x      = uv_x;
        item.uv_y      = uv_y;
        item.uv_width  = uv_width;
        item.uv_height = uv_height;
        item.color     = color;
    end

    // sine and cosine, sprite fields travel alongside
    sqvt_trig u_trig (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_item   (item),
        .out_valid (trig_valid),
        .out_item  (trig_item),
        .sn        (trig_sn),
        .cs        (trig_cs)
    );

    // four transformed corners plus texture corners
    sqvt_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (trig_valid),
        .in_item   (trig_item),
        .sn        (trig_sn),
        .cs        (trig_cs),
        .out_valid (geom_valid),
        .out_quad  (geom_quad)
    );

    // six vertex beats per quad
    sqvt_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (geom_valid),
        .in_quad      (geom_quad),
        .done         (done),
        .vertex_x     (vertex_x),
        .vertex_y     (vertex_y),
        .tex_u        (tex_u),
        .tex_v        (tex_v),
        .vertex_color (vertex_color),
        .corner       (corner),
        .last         (last)
    );

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// testbench for sprite_quad_vertex_transform: random and directed sprites, six vertices each
// depends on sqvt_pkg and the block's rtl; predicts vertices and checks every done beat

module tb;
    import sqvt_pkg::*;

    // vertex as predicted
    typedef struct {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [TEX_W-1:0]        u;
        logic [TEX_W-1:0]        v;
        logic [COLOR_W-1:0]      col;
        logic [1:0]              cnr;
        logic                    lst;
    } vertex_t;

    localparam longint ONE30   = 64'sd1 << 30;
    localparam longint HPI30   = 64'sd1686629713;
    localparam longint SAT_MAX = 64'sd8388607;
    localparam longint SAT_MIN = -64'sd8388608;
    localparam int WATCHDOG    = 2000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    item_t sprite;
    logic done;
    logic signed [POS_W-1:0] vertex_x;
    logic signed [POS_W-1:0] vertex_y;
    logic [TEX_W-1:0] tex_u;
    logic [TEX_W-1:0] tex_v;
    logic [COLOR_W-1:0] vertex_color;
    logic [1:0] corner;
    logic last;

    item_t   sprite_q[$];
    vertex_t vertex_q[$];
    int  gap_left;
    int  idle_cycles;
    bit  failed;
    bit  stim_done;

    sprite_quad_vertex_transform uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .pos_x(sprite.pos_x), .pos_y(sprite.pos_y),
        .pivot_x(sprite.pivot_x), .pivot_y(sprite.pivot_y),
        .scale_x(sprite.scale_x), .scale_y(sprite.scale_y),
        .angle(sprite.angle), .uv_x(sprite.uv_x), .uv_y(sprite.uv_y),
        .uv_width(sprite.uv_width), .uv_height(sprite.uv_height), .color(sprite.color),
        .done(done), .vertex_x(vertex_x), .vertex_y(vertex_y), .tex_u(tex_u),
        .tex_v(tex_v), .vertex_color(vertex_color), .corner(corner), .last(last)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // division by 2^s on signed values, rounded half up; >>> on longint floors
    function automatic longint round_half_up(longint v, int s);
        return (v + (64'sd1 << (s - 1))) >>> s;
    endfunction

    function automatic longint horner(longint t2, longint r, longint k);
        longint n;
        n = ONE30 - ((t2 * r) >>> 30) / k;
        return (n < 0) ? 0 : n;
    endfunction

    function automatic longint clamp_pos(longint v);
        if (v > SAT_MAX)
            return SAT_MAX;
        if (v < SAT_MIN)
            return SAT_MIN;
        return v;
    endfunction

    // append one sprite to the pending queue
    task automatic enqueue_sprite(item_t it);
        sprite_q = {sprite_q, it};
    endtask

    // six vertices of one sprite quad, appended to the expected queue
    task automatic predict_quad(item_t it);
        longint t, t2, r, s, c, sn, cs, lx, ly, sx, sy, rx, ry;
        longint vx[4], vy[4];
        logic [1:0] quad;
        logic [1:0] cn;
        vertex_t vt;
        quad = it.angle[15:14];
        t  = (longint'(it.angle[13:0]) * HPI30) >>> 14;
        t2 = (t * t) >>> 30;
        r = ONE30;
        r = horner(t2, r, 110);
        r = horner(t2, r, 72);
        r = horner(t2, r, 42);
        r = horner(t2, r, 20);
        r = horner(t2, r, 6);
        s = (t * r) >>> 30;
        if (s > ONE30)
            s = ONE30;
        c = ONE30;
        c = horner(t2, c, 132);
        c = horner(t2, c, 90);
        c = horner(t2, c, 56);
        c = horner(t2, c, 30);
        c = horner(t2, c, 12);
        c = horner(t2, c, 2);
        s = (s + (64'sd1 << 13)) >>> 14;
        c = (c + (64'sd1 << 13)) >>> 14;
        case (quad)
            2'd0:    begin sn = s;  cs = c;  end
            2'd1:    begin sn = c;  cs = -s; end
            2'd2:    begin sn = -s; cs = -c; end
            default: begin sn = -c; cs = s;  end
        endcase
        for (int k = 0; k < 4; k++)
        begin
            lx = k[0] ? longint'(it.uv_width) << FRAC_BITS : 0;
            ly = k[1] ? longint'(it.uv_height) << FRAC_BITS : 0;
            sx = round_half_up((lx - longint'(it.pivot_x)) * longint'(it.scale_x), 8);
            sy = round_half_up((ly - longint'(it.pivot_y)) * longint'(it.scale_y), 8);
            rx = round_half_up(sx * cs - sy * sn, 16);
            ry = round_half_up(sx * sn + sy * cs, 16);
            vx[k] = clamp_pos(longint'(it.pos_x) + rx);
            vy[k] = clamp_pos(longint'(it.pos_y) + ry);
        end
        for (int b = 0; b < 6; b++)
        begin
            cn = ORDER[b];
            vt.x   = vx[cn][POS_W-1:0];
            vt.y   = vy[cn][POS_W-1:0];
            vt.u   = cn[0] ? TEX_W'(it.uv_x) + TEX_W'(it.uv_width) : TEX_W'(it.uv_x);
            vt.v   = cn[1] ? TEX_W'(it.uv_y) + TEX_W'(it.uv_height) : TEX_W'(it.uv_y);
            vt.col = it.color;
            vt.cnr = cn;
            vt.lst = (b == 5);
            vertex_q = {vertex_q, vt};
        end
    endtask

    function automatic item_t random_sprite();
        item_t it;
        logic [255:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom};
        it = bits[$bits(item_t)-1:0];
        // mostly modest sizes and scales so the quads stay in range; some wild ones
        if ($urandom_range(0, 3) != 0)
        begin
            it.pos_x     = $signed(24'($urandom_range(0, 2000000))) - 24'sd1000000;
            it.pos_y     = $signed(24'($urandom_range(0, 2000000))) - 24'sd1000000;
            it.pivot_x   = $signed(24'($urandom_range(0, 40000))) - 24'sd20000;
            it.pivot_y   = $signed(24'($urandom_range(0, 40000))) - 24'sd20000;
            it.scale_x   = $signed(16'($urandom_range(0, 2048))) - 16'sd1024;
            it.scale_y   = $signed(16'($urandom_range(0, 2048))) - 16'sd1024;
            it.uv_width  = UV_W'($urandom_range(0, 512));
            it.uv_height = UV_W'($urandom_range(0, 512));
        end
        return it;
    endfunction

    function automatic item_t make_sprite(int px, int py, int vx, int vy, int sx, int sy,
                                          int ang, int w, int h);
        item_t it;
        it = '0;
        it.pos_x = POS_W'(px);  it.pos_y = POS_W'(py);
        it.pivot_x = POS_W'(vx);  it.pivot_y = POS_W'(vy);
        it.scale_x = SCALE_W'(sx);  it.scale_y = SCALE_W'(sy);  it.angle = ANGLE_W'(ang);
        it.uv_x = UV_W'(100);  it.uv_y = UV_W'(200);
        it.uv_width = UV_W'(w);  it.uv_height = UV_W'(h);
        it.color = 32'hA5C3_0F81;
        return it;
    endfunction

    // driver: one sprite per start beat, sometimes back to back, else after a random hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            sprite   <= '0;
            gap_left <= 0;
        end
        else if (start && !busy)
        begin
            // beat taken this edge
            predict_quad(sprite);
            if (sprite_q.size() != 0 && $urandom_range(0, 3) == 0)
            begin
                sprite <= sprite_q.pop_front();
            end
            else
            begin
                start    <= 1'b0;
                gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
            end
        end
        else if (!start && sprite_q.size() != 0)
        begin
            if (gap_left == 0)
            begin
                start  <= 1'b1;
                sprite <= sprite_q.pop_front();
            end
            else
            begin
                gap_left <= gap_left - 1;
            end
        end
    end

    // monitor: every done beat against the oldest predicted vertex
    always @(posedge clk)
    begin
        vertex_t e;
        if (rst_n && done)
        begin
            if (vertex_q.size() == 0)
            begin
                $error("vertex with nothing expected");
                failed <= 1'b1;
            end
            else
            begin
                e = vertex_q.pop_front();
                if (vertex_x !== e.x)
                begin
                    $error("vertex_x expected %0d got %0d", e.x, vertex_x);
                    failed <= 1'b1;
                end
                if (vertex_y !== e.y)
                begin
                    $error("vertex_y expected %0d got %0d", e.y, vertex_y);
                    failed <= 1'b1;
                end
                if (tex_u !== e.u)
                begin
                    $error("tex_u expected %0d got %0d", e.u, tex_u);
                    failed <= 1'b1;
                end
                if (tex_v !== e.v)
                begin
                    $error("tex_v expected %0d got %0d", e.v, tex_v);
                    failed <= 1'b1;
                end
                if (vertex_color !== e.col)
                begin
                    $error("vertex_color expected %h got %h", e.col, vertex_color);
                    failed <= 1'b1;
                end
                if (corner !== e.cnr)
                begin
                    $error("corner expected %0d got %0d", e.cnr, corner);
                    failed <= 1'b1;
                end
                if (last !== e.lst)
                begin
                    $error("last expected %0d got %0d", e.lst, last);
                    failed <= 1'b1;
                end
            end
        end
    end

    // watchdog on cycles with no beat either way
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        failed    = 1'b0;
        stim_done = 1'b0;
        idle_cycles = 0;
        rst_n = 1'b0;
        // directed: extremes, each quadrant, zero size, mirroring, saturation
        enqueue_sprite(make_sprite(0, 0, 0, 0, 256, 256, 0, 0, 0));
        enqueue_sprite(make_sprite(1000, -1000, 0, 0, 256, 256, 0, 16, 8));
        enqueue_sprite(make_sprite(0, 0, 2048, 1024, 256, 256, 16'h4000, 32, 16));
        enqueue_sprite(make_sprite(0, 0, 2048, 1024, 256, 256, 16'h8000, 32, 16));
        enqueue_sprite(make_sprite(0, 0, 2048, 1024, 256, 256, 16'hC000, 32, 16));
        enqueue_sprite(make_sprite(0, 0, 0, 0, 512, 384, 16'h2000, 100, 50));
        enqueue_sprite(make_sprite(0, 0, 0, 0, 256, 256, 16'hFFFF, 100, 50));
        enqueue_sprite(make_sprite(0, 0, 0, 0, 256, 256, 16'h3FFF, 100, 50));
        enqueue_sprite(make_sprite(0, 0, 0, 0, -256, -512, 16'h1234, 64, 64));
        enqueue_sprite(make_sprite(8388607, 8388607, 0, 0, 32767, 32767, 0, 32767, 32767));
        enqueue_sprite(make_sprite(-8388608, -8388608, 0, 0, 32767, 32767, 16'h8000,
                                   32767, 32767));
        enqueue_sprite(make_sprite(0, 0, -8388608, 8388607, -32768, -32768, 16'h6000,
                                   32767, 0));
        enqueue_sprite(make_sprite(0, 0, 8388607, -8388608, 32767, -32768, 16'hA000,
                                   0, 32767));
        enqueue_sprite(make_sprite(-5, 7, 1, -1, 1, -1, 16'h0001, 1, 1));
        begin
            item_t it;
            it = '1;
            enqueue_sprite(it);
            it = make_sprite(0, 0, 0, 0, 0, 0, 16'hE000, 0, 0);
            it.uv_x = 15'h7FFF;  it.uv_y = 15'h7FFF;  it.color = 32'h0;
            enqueue_sprite(it);
        end
        for (int i = 0; i < 440; i++)
            enqueue_sprite(random_sprite());
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        // wait for every sprite taken and every vertex seen
        wait (sprite_q.size() == 0 && !start);
        @(posedge clk);
        wait (vertex_q.size() == 0);
        repeat (40) @(posedge clk);
        if (!failed && vertex_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
